@@ rtl/fir_filter_loadable_taps_assert.svh @@
// Assertion shorthands used by the checker file fir_lt_chk.sv.
// Every macro samples on the rising edge of clk and is off while rst_n is low.
`ifndef FIR_FILTER_LOADABLE_TAPS_ASSERT_SVH
`define FIR_FILTER_LOADABLE_TAPS_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FLT_ASSERT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FLT_ASSERT_NEXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/fir_lt_pkg.sv @@
package fir_lt_pkg;

    // Fixed field widths
    localparam int COEF_W = 18;
    localparam int FRAC_W = 16;
    localparam int CNT_W  = 6;
    localparam int IDX_W  = 5;

    // Request type codes
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_COEF   = 1'b1;

    // Tap count after reset
    localparam logic [CNT_W-1:0] TAP_COUNT_RST = 6'd20;

    // Controls from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic clear;   // start a new sum
        logic op_vld;  // memory read data is valid this cycle
    } mac_ctl_t;

endpackage

@@ rtl/fir_lt_in_if.sv @@
interface fir_lt_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                                   valid;
    logic                                   ready;
    logic                                   req_type;
    logic signed [SAMPLE_BITS-1:0]          sample_in;
    logic [fir_lt_pkg::IDX_W-1:0]           coef_index;
    logic signed [fir_lt_pkg::COEF_W-1:0]   coef_value;

    modport source (
        output valid, req_type, sample_in, coef_index, coef_value,
        input  ready
    );
    modport sink (
        input  valid, req_type, sample_in, coef_index, coef_value,
        output ready
    );
endinterface

@@ rtl/fir_lt_out_if.sv @@
interface fir_lt_out_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] filtered;
    logic                          clipped;

    modport source (
        output valid, filtered, clipped,
        input  ready
    );
    modport sink (
        input  valid, filtered, clipped,
        output ready
    );
endinterface

@@ rtl/fir_lt_cfg_if.sv @@
interface fir_lt_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [fir_lt_pkg::CNT_W-1:0] data;

    modport source (
        output valid, data,
        input  ready
    );
    modport sink (
        input  valid, data,
        output ready
    );
endinterface

@@ rtl/fir_filter_loadable_taps.sv @@
// Channel | Dir | Transaction                | Payload
// din     | in  | sample or coefficient load | req_type, sample_in, coef_index, coef_value
// dout    | out | one filtered sample        | filtered, clipped
// cfg     | in  | tap count write            | data
//
// A coefficient load or a warm-up sample leaves din ready.
// A sample that yields a result holds din not ready while the taps are read,
// one per cycle from the two memory read ports into the shared multiplier,
// then while the product and accumulate stages drain and the result loads;
// only after that can the next sample enter. Reset needs no clearing pass.
// A result held on dout only stalls the final load of the output register.
module fir_filter_loadable_taps #(
    parameter int MAX_TAPS    = 32,
    parameter int SAMPLE_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    fir_lt_in_if.sink     din,
    fir_lt_out_if.source  dout,
    fir_lt_cfg_if.sink    cfg
);

    localparam int AW = $clog2(MAX_TAPS);
    localparam int CW = fir_lt_pkg::CNT_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } state_t;

    state_t                        state_reg, state_next;
    logic [AW-1:0]                 ptr_reg, ptr_next;
    logic [AW-1:0]                 rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]                 iss_cnt_reg, iss_cnt_next;
    logic [CW-1:0]                 warm_reg, warm_next;
    logic [CW-1:0]                 tap_count_reg, tap_count_next;
    logic                          rd_vld_reg, rd_vld_next;
    logic                          out_valid_reg, out_valid_next;
    logic signed [SAMPLE_BITS-1:0] filtered_reg, filtered_next;
    logic                          clipped_reg, clipped_next;

    logic [CW-1:0]                 eff_taps;
    logic                          in_fire;
    logic                          is_coef;
    logic [AW-1:0]                 ptr_inc;
    logic [AW-1:0]                 rd_ptr_dec;
    logic                          out_free;
    logic                          load;

    fir_lt_pkg::mac_ctl_t                 mac_ctl;
    logic                                 mac_busy;
    logic signed [SAMPLE_BITS-1:0]        mac_filtered;
    logic                                 mac_clipped;
    logic signed [SAMPLE_BITS-1:0]        dly_rdata;
    logic signed [fir_lt_pkg::COEF_W-1:0] tap_rdata;
    logic                                 dly_we;
    logic                                 tap_we;

    // Clamp the tap count to the supported range
    always_comb
    begin
        if (tap_count_reg == '0)
        begin
            eff_taps = CW'(1);
        end
        else if (int'(tap_count_reg) > MAX_TAPS)
        begin
            eff_taps = CW'(MAX_TAPS);
        end
        else
        begin
            eff_taps = tap_count_reg;
        end
    end

    assign in_fire    = din.valid && din.ready;
    assign is_coef    = (din.req_type == fir_lt_pkg::REQ_COEF);
    assign ptr_inc    = (ptr_reg == AW'(MAX_TAPS - 1)) ? '0 : ptr_reg + AW'(1);
    assign rd_ptr_dec = (rd_ptr_reg == '0) ? AW'(MAX_TAPS - 1) : rd_ptr_reg - AW'(1);
    assign out_free   = !out_valid_reg || dout.ready;

    // Memory writes: newest sample one slot past the head, taps by index
    assign dly_we = in_fire && !is_coef;
    assign tap_we = in_fire && is_coef && (int'(din.coef_index) < MAX_TAPS);

    // Sequencer: accept, walk the taps, drain and hand over the result
    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        rd_ptr_next    = rd_ptr_reg;
        iss_cnt_next   = iss_cnt_reg;
        warm_next      = warm_reg;
        rd_vld_next    = 1'b0;
        mac_ctl.clear  = 1'b0;
        mac_ctl.op_vld = rd_vld_reg;
        load           = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && !is_coef)
                begin
                    ptr_next = ptr_inc;
                    if (warm_reg < eff_taps)
                    begin
                        warm_next = warm_reg + CW'(1);
                    end
                    else
                    begin
                        mac_ctl.clear = 1'b1;
                        iss_cnt_next  = '0;
                        rd_ptr_next   = ptr_inc;
                        state_next    = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                rd_vld_next  = 1'b1;
                rd_ptr_next  = rd_ptr_dec;
                iss_cnt_next = iss_cnt_reg + CW'(1);
                if (iss_cnt_reg == eff_taps - CW'(1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!rd_vld_reg && !mac_busy && out_free)
                begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register: load a finished sum, drop it once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        filtered_next  = filtered_reg;
        clipped_next   = clipped_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            filtered_next  = mac_filtered;
            clipped_next   = mac_clipped;
        end
        else if (dout.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Tap count register
    assign tap_count_next = cfg.valid ? cfg.data : tap_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ptr_reg       <= '0;
            rd_ptr_reg    <= '0;
            iss_cnt_reg   <= '0;
            warm_reg      <= '0;
            tap_count_reg <= fir_lt_pkg::TAP_COUNT_RST;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            filtered_reg  <= '0;
            clipped_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            iss_cnt_reg   <= iss_cnt_next;
            warm_reg      <= warm_next;
            tap_count_reg <= tap_count_next;
            rd_vld_reg    <= rd_vld_next;
            out_valid_reg <= out_valid_next;
            filtered_reg  <= filtered_next;
            clipped_reg   <= clipped_next;
        end
    end

    assign din.ready     = (state_reg == ST_IDLE);
    assign cfg.ready     = 1'b1;
    assign dout.valid    = out_valid_reg;
    assign dout.filtered = filtered_reg;
    assign dout.clipped  = clipped_reg;

    fir_lt_mem #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mem (
        .clk       (clk),
        .dly_we    (dly_we),
        .dly_waddr (ptr_inc),
        .dly_wdata (din.sample_in),
        .dly_raddr (rd_ptr_reg),
        .dly_rdata (dly_rdata),
        .tap_we    (tap_we),
        .tap_waddr (AW'(din.coef_index)),
        .tap_wdata (din.coef_value),
        .tap_raddr (AW'(iss_cnt_reg)),
        .tap_rdata (tap_rdata)
    );

    fir_lt_mac #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (mac_ctl),
        .sample   (dly_rdata),
        .coef     (tap_rdata),
        .busy     (mac_busy),
        .filtered (mac_filtered),
        .clipped  (mac_clipped)
    );

endmodule

@@ rtl/fir_lt_mem.sv @@
module fir_lt_mem #(
    parameter int MAX_TAPS    = 32,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                  clk,
    // delay line port
    input  logic                                  dly_we,
    input  logic [$clog2(MAX_TAPS)-1:0]           dly_waddr,
    input  logic signed [SAMPLE_BITS-1:0]         dly_wdata,
    input  logic [$clog2(MAX_TAPS)-1:0]           dly_raddr,
    output logic signed [SAMPLE_BITS-1:0]         dly_rdata,
    // coefficient port
    input  logic                                  tap_we,
    input  logic [$clog2(MAX_TAPS)-1:0]           tap_waddr,
    input  logic signed [fir_lt_pkg::COEF_W-1:0]  tap_wdata,
    input  logic [$clog2(MAX_TAPS)-1:0]           tap_raddr,
    output logic signed [fir_lt_pkg::COEF_W-1:0]  tap_rdata
);

    logic signed [SAMPLE_BITS-1:0]        dly_mem [MAX_TAPS];
    logic signed [fir_lt_pkg::COEF_W-1:0] tap_mem [MAX_TAPS];

    // Delay line: circular buffer, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (dly_we)
        begin
            dly_mem[dly_waddr] <= dly_wdata;
        end
        dly_rdata <= dly_mem[dly_raddr];
    end

    // Coefficient store: one write and one registered read
    always_ff @(posedge clk)
    begin
        if (tap_we)
        begin
            tap_mem[tap_waddr] <= tap_wdata;
        end
        tap_rdata <= tap_mem[tap_raddr];
    end

endmodule

@@ rtl/fir_lt_mac.sv @@
module fir_lt_mac #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  fir_lt_pkg::mac_ctl_t                  ctl,
    input  logic signed [SAMPLE_BITS-1:0]         sample,
    input  logic signed [fir_lt_pkg::COEF_W-1:0]  coef,
    output logic                                  busy,
    output logic signed [SAMPLE_BITS-1:0]         filtered,
    output logic                                  clipped
);

    localparam int PROD_W  = SAMPLE_BITS + fir_lt_pkg::COEF_W;
    localparam int ACC_W   = PROD_W + fir_lt_pkg::CNT_W;
    localparam int TOP_LSB = fir_lt_pkg::FRAC_W + SAMPLE_BITS - 1;
    localparam logic signed [ACC_W:0] HALF = (ACC_W+1)'(1) <<< (fir_lt_pkg::FRAC_W - 1);

    logic                     prod_vld_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W:0]    rnd;
    logic                     pos_ovf;
    logic                     neg_ovf;

    // Product stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= ctl.op_vld;
        end
    end

    // Register the product before it reaches the adder
    always_ff @(posedge clk)
    begin
        prod_reg <= sample * coef;
    end

    // Clear on a new item, otherwise add each product
    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.clear)
        begin
            acc_next = '0;
        end
        else if (prod_vld_reg)
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign busy = prod_vld_reg;

    // Round half up, drop the fraction, saturate to the sample width
    always_comb
    begin
        rnd     = (ACC_W+1)'(acc_reg) + HALF;
        pos_ovf = !rnd[ACC_W] && (|rnd[ACC_W-1:TOP_LSB]);
        neg_ovf = rnd[ACC_W] && !(&rnd[ACC_W-1:TOP_LSB]);
        if (pos_ovf)
        begin
            filtered = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
        else if (neg_ovf)
        begin
            filtered = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end
        else
        begin
            filtered = rnd[TOP_LSB:fir_lt_pkg::FRAC_W];
        end
        clipped = pos_ovf || neg_ovf;
    end

endmodule

@@ rtl/fir_lt_chk.sv @@
`include "fir_filter_loadable_taps_assert.svh"

module fir_lt_chk #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic                   in_req_type,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [SAMPLE_BITS-1:0] out_filtered,
    input logic                   out_clipped
);

    localparam logic [SAMPLE_BITS-1:0] SAT_HI = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SAT_LO = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // Hold a stalled result
    `FLT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_filtered) && $stable(out_clipped), "result changed while stalled")

    // A clipped result sits at one of the two rails
    `FLT_ASSERT(a_clip_rail, out_valid && out_clipped, out_filtered == SAT_HI || out_filtered == SAT_LO, "clipped result off the rails")

    // Busy only after a sample transaction
    `FLT_ASSERT(a_busy_cause, $fell(in_ready), $past(in_valid && in_req_type == fir_lt_pkg::REQ_SAMPLE), "input stalled without a sample")

    // A new result follows a filter pass
    `FLT_ASSERT(a_out_cause, $rose(out_valid), $past(!in_ready), "result without a filter pass")

endmodule

bind fir_filter_loadable_taps fir_lt_chk #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (din.valid),
    .in_ready     (din.ready),
    .in_req_type  (din.req_type),
    .out_valid    (dout.valid),
    .out_ready    (dout.ready),
    .out_filtered (dout.filtered),
    .out_clipped  (dout.clipped)
);

@@ sim/fir_filter_loadable_taps_tb.sv @@
`timescale 1ns / 100ps

module fir_filter_loadable_taps_tb;

    localparam int MAX_TAPS       = 32;
    localparam int SAMPLE_BITS    = 16;
    localparam int SETTLE_CYCLES  = MAX_TAPS + 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int NUM_PHASES     = 8;
    localparam int PHASE_ITEMS    = 80;

    // Golden FIR: delay line, tap store and warm-up counter, plus the queue of
    // filtered samples still owed by the block.
    class fir_tap_scoreboard;
        typedef struct {
            logic signed [SAMPLE_BITS-1:0] filtered;
            logic                          clipped;
        } filter_out_t;

        logic signed [SAMPLE_BITS-1:0]        history[MAX_TAPS];
        logic signed [fir_lt_pkg::COEF_W-1:0] coefs[MAX_TAPS];
        int unsigned                          warm_count;
        logic [fir_lt_pkg::CNT_W-1:0]         tap_count;
        filter_out_t                          pending_outputs[$];
        int                                   mismatches;
        int                                   coef_loads;
        int                                   samples_in;
        int                                   results_ok;
        int                                   clipped_seen;

        function new();
            foreach (history[i])
            begin
                history[i] = '0;
                coefs[i]   = '0;
            end
            warm_count = 0;
            tap_count  = fir_lt_pkg::TAP_COUNT_RST;
        endfunction

        function void set_tap_count(logic [fir_lt_pkg::CNT_W-1:0] value);
            tap_count = value;
        endfunction

        function int unsigned active_taps();
            if (tap_count == 0)
                return 1;
            if (tap_count > MAX_TAPS)
                return MAX_TAPS;
            return tap_count;
        endfunction

        function int pending();
            return pending_outputs.size();
        endfunction

        // Note one accepted input transaction and queue the filtered sample it owes.
        function void load_item(logic req, logic signed [SAMPLE_BITS-1:0] sample,
                                logic [fir_lt_pkg::IDX_W-1:0] idx,
                                logic signed [fir_lt_pkg::COEF_W-1:0] coef);
            longint      acc;
            longint      rounded;
            int unsigned taps;
            filter_out_t want;
            if (req == fir_lt_pkg::REQ_COEF)
            begin
                coefs[idx] = coef;
                coef_loads++;
                return;
            end
            samples_in++;
            for (int i = MAX_TAPS - 1; i > 0; i--)
                history[i] = history[i-1];
            history[0] = sample;
            taps = active_taps();
            // Hold off output until enough history has arrived
            if (warm_count < taps)
            begin
                warm_count++;
                return;
            end
            acc = 0;
            for (int i = 0; i < taps; i++)
                acc += longint'(history[i]) * longint'(coefs[i]);
            // Round half toward plus infinity, then drop the fraction bits
            rounded = (acc + (longint'(1) <<< (fir_lt_pkg::FRAC_W - 1))) >>> fir_lt_pkg::FRAC_W;
            want.clipped = 1'b1;
            if (rounded > (2**(SAMPLE_BITS-1)) - 1)
                rounded = (2**(SAMPLE_BITS-1)) - 1;
            else if (rounded < -(2**(SAMPLE_BITS-1)))
                rounded = -(2**(SAMPLE_BITS-1));
            else
                want.clipped = 1'b0;
            want.filtered = rounded[SAMPLE_BITS-1:0];
            pending_outputs.push_back(want);
        endfunction

        // Compare one output transaction with the oldest owed sample.
        function void check_output(logic signed [SAMPLE_BITS-1:0] got_val, logic got_clip);
            filter_out_t want;
            if (pending_outputs.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected output filtered=%0d clipped=%0b",
                             got_val, got_clip);
                return;
            end
            want = pending_outputs.pop_front();
            if (got_val !== want.filtered || got_clip !== want.clipped)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: filtered exp=%0d got=%0d, clipped exp=%0b got=%0b",
                             want.filtered, got_val, want.clipped, got_clip);
            end
            else
            begin
                results_ok++;
                if (got_clip)
                    clipped_seen++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    fir_lt_in_if #(.SAMPLE_BITS(SAMPLE_BITS))  din_if ();
    fir_lt_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) dout_if ();
    fir_lt_cfg_if                              cfg_if ();

    fir_filter_loadable_taps #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din_if),
        .dout  (dout_if),
        .cfg   (cfg_if)
    );

    fir_tap_scoreboard fir_sb = new();

    int  burst_left;
    bit  steady_sender;
    int  idle_cycles = 0;
    int  settings_applied;
    int  stall_left = 0;
    int  ready_cycle = 0;

    always #10 clk = ~clk;

    // Stall the output side: the stall style changes with the upper bits of a free-running counter
    always @(posedge clk)
    begin
        ready_cycle <= ready_cycle + 1;
        if (!rst_n)
            dout_if.ready <= 1'b0;
        else if (stall_left > 0)
        begin
            dout_if.ready <= 1'b0;
            stall_left    <= stall_left - 1;
        end
        else
        begin
            dout_if.ready <= 1'b1;
            case (ready_cycle[9:8])
                2'd1: if ($urandom_range(0, 3) == 0) stall_left <= $urandom_range(1, 3);
                2'd2: if ($urandom_range(0, 15) == 0) stall_left <= $urandom_range(5, 30);
                2'd3: if ($urandom_range(0, 1) == 0) stall_left <= 1;
                default: stall_left <= 0;
            endcase
        end
    end

    // Watch both data channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (din_if.valid && din_if.ready)
                fir_sb.load_item(din_if.req_type, din_if.sample_in,
                                 din_if.coef_index, din_if.coef_value);
            if (dout_if.valid && dout_if.ready)
                fir_sb.check_output(dout_if.filtered, dout_if.clipped);
        end
    end

    // End the run when no transaction moves for too long
    always @(posedge clk)
    begin
        if ((din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("ERROR: watchdog expired with %0d outputs owed", fir_sb.pending());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Present one input transaction; the sender may idle between bursts
    task automatic drive_item(input logic req, input logic signed [SAMPLE_BITS-1:0] sample,
                              input logic [fir_lt_pkg::IDX_W-1:0] idx,
                              input logic signed [fir_lt_pkg::COEF_W-1:0] coef);
        int gap;
        if (burst_left == 0)
        begin
            if (steady_sender)
                gap = 0;
            else if ($urandom_range(0, 3) == 0)
                gap = $urandom_range(1, 20);
            else
                gap = $urandom_range(0, 2);
            if (gap > 0)
            begin
                din_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        din_if.valid      <= 1'b1;
        din_if.req_type   <= req;
        din_if.sample_in  <= sample;
        din_if.coef_index <= idx;
        din_if.coef_value <= coef;
        do
            @(posedge clk);
        while (!din_if.ready);
    endtask

    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] sample);
        drive_item(fir_lt_pkg::REQ_SAMPLE, sample, fir_lt_pkg::IDX_W'($urandom),
                   fir_lt_pkg::COEF_W'($urandom));
    endtask

    task automatic send_coef(input logic [fir_lt_pkg::IDX_W-1:0] idx,
                             input logic signed [fir_lt_pkg::COEF_W-1:0] coef);
        drive_item(fir_lt_pkg::REQ_COEF, SAMPLE_BITS'($urandom), idx, coef);
    endtask

    // Drop valid, wait for every owed output, then let the pipeline settle
    task automatic settle();
        din_if.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (fir_sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_tap_count(input logic [fir_lt_pkg::CNT_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= value;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        fir_sb.set_tap_count(value);
        settings_applied++;
    endtask

    // Mostly modest taps so outputs span the range; some full-scale and extremes
    function automatic logic signed [fir_lt_pkg::COEF_W-1:0] rand_coef();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 3)
            return fir_lt_pkg::COEF_W'($urandom);
        if (pick == 3)
            return ($urandom_range(0, 1) != 0) ? 18'sd131071 : -18'sd131072;
        return fir_lt_pkg::COEF_W'(int'($urandom_range(0, 8192)) - 4096);
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 7)
            return SAMPLE_BITS'($urandom);
        if (pick < 9)
            return SAMPLE_BITS'(int'($urandom_range(0, 512)) - 256);
        return ($urandom_range(0, 1) != 0) ? 16'sd32767 : -16'sd32768;
    endfunction

    initial
    begin
        int                           tap_plan[NUM_PHASES];
        logic [fir_lt_pkg::CNT_W-1:0] tap_setting;

        // Drive every input to a known value from time zero
        din_if.valid      <= 1'b0;
        din_if.req_type   <= fir_lt_pkg::REQ_SAMPLE;
        din_if.sample_in  <= '0;
        din_if.coef_index <= '0;
        din_if.coef_value <= '0;
        cfg_if.valid      <= 1'b0;
        cfg_if.data       <= '0;

        burst_left       = 0;
        steady_sender    = 1'b0;
        settings_applied = 0;
        tap_plan = '{32, 0, 63, 1, 33, 2, 0, 0};
        tap_plan[6] = $urandom_range(3, 31);
        tap_plan[7] = $urandom_range(1, 32);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Two taps at opposite full scale: saturate both ways
        write_tap_count(6'd2);
        send_coef(5'd0, 18'sd131071);
        send_coef(5'd1, -18'sd131072);
        send_sample(16'sd32767);
        send_sample(-16'sd32768);
        send_sample(16'sd32767);
        send_sample(-16'sd32768);
        // Unity tap passes the sample through
        send_coef(5'd0, 18'sd65536);
        send_coef(5'd1, 18'sd0);
        send_sample(16'sd12345);
        // Half tap: ties round toward plus infinity
        send_coef(5'd0, 18'sd32768);
        send_sample(16'sd1);
        send_sample(-16'sd1);
        send_sample(-16'sd3);
        send_sample(16'sd0);
        settle();

        // Shrink the tap count after the stream settles, then a zero tap count (one tap)
        write_tap_count(6'd1);
        send_sample(16'sd7);
        send_sample(-16'sd32768);
        settle();
        write_tap_count(6'd0);
        send_sample(16'sd32767);
        send_sample(-16'sd5);
        settle();

        // Random phases, each under its own tap count
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            tap_setting = fir_lt_pkg::CNT_W'(tap_plan[p]);
            write_tap_count(tap_setting);
            steady_sender = (p == 2);
            // Fill the whole tap store before the first long filter runs
            if (p == 0)
                for (int i = 0; i < MAX_TAPS; i++)
                    send_coef(fir_lt_pkg::IDX_W'(i), rand_coef());
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 99) < 12)
                    send_coef(fir_lt_pkg::IDX_W'($urandom), rand_coef());
                else
                    send_sample(rand_sample());
            end
            settle();
        end

        $display("Run covered %0d coefficient loads and %0d samples over %0d tap settings,",
                 fir_sb.coef_loads, fir_sb.samples_in, settings_applied);
        $display("with %0d filtered outputs matched, %0d of them saturated.",
                 fir_sb.results_ok, fir_sb.clipped_seen);
        if (fir_sb.mismatches == 0)
            $display("Simulation PASSED");
        else
        begin
            $display("%0d mismatches in total", fir_sb.mismatches);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
